FILE: rtl/core/tang_pkg.sv
package tang_pkg;

	typedef struct packed {
		logic [31:0] side_a;
		logic [31:0] side_b;
		logic [31:0] side_c;
	} sides_t;

	typedef struct packed {
		logic [31:0] angle_alpha;
		logic [31:0] angle_beta;
		logic [31:0] angle_gamma;
		logic        degenerate;
	} angles_t;

	localparam int LANES = 3;

	typedef struct packed {
		logic             valid;
		logic             degen;
		logic [LANES-1:0] neg;
	} ctl_t;

	localparam int DIV_STEPS    = 30;
	localparam int SQRT_STEPS   = 31;
	localparam int CORDIC_SCALE = 16;
	localparam int ZW           = 34;

	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
	localparam logic [31:0] PI_Q30      = 32'd3373259426;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [60:0] ONE_Q60     = 61'h1000_0000_0000_0000;

	function automatic logic [1:0] lane_p(input int k);
		return (k == 0) ? 2'd1 : 2'd0;
	endfunction

	function automatic logic [1:0] lane_q(input int k);
		return (k == 2) ? 2'd1 : 2'd2;
	endfunction

	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] t;
		case (i)
			0:  t = 32'h3243F6A8;
			1:  t = 32'h1DAC6705;
			2:  t = 32'h0FADBAFC;
			3:  t = 32'h07F56EA6;
			4:  t = 32'h03FEAB76;
			5:  t = 32'h01FFD55B;
			6:  t = 32'h00FFFAAA;
			7:  t = 32'h007FFF55;
			8:  t = 32'h003FFFEA;
			9:  t = 32'h001FFFFD;
			10: t = 32'h000FFFFF;
			11: t = 32'h0007FFFF;
			12: t = 32'h0003FFFF;
			13: t = 32'h0001FFFF;
			14: t = 32'h0000FFFF;
			15: t = 32'h00007FFF;
			16: t = 32'h00003FFF;
			17: t = 32'h00001FFF;
			18: t = 32'h00000FFF;
			19: t = 32'h000007FF;
			20: t = 32'h000003FF;
			21: t = 32'h000001FF;
			22: t = 32'h000000FF;
			23: t = 32'h0000007F;
			24: t = 32'h0000003F;
			25: t = 32'h0000001F;
			26: t = 32'h0000000F;
			27: t = 32'h00000008;
			28: t = 32'h00000004;
			29: t = 32'h00000002;
			30: t = 32'h00000001;
			default: t = 32'h0;
		endcase
		return t;
	endfunction

endpackage

FILE: rtl/core/tang_front.sv
module tang_front import tang_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        sides_valid,
	input  sides_t      sides,
	output ctl_t        ctl,
	output logic [64:0] mag [LANES],
	output logic [64:0] den [LANES]
);

	logic        v_s1, v_s2, v_s3;
	logic        dg_s1, dg_s2, dg_s3;
	logic [63:0] sq_s1 [LANES];
	logic [63:0] pq_s1 [LANES];
	logic [64:0] sum_s2 [LANES];
	logic [63:0] rr_s2 [LANES];
	logic [64:0] den_s2 [LANES];
	logic [64:0] mag_s3 [LANES];
	logic [64:0] den_s3 [LANES];
	logic [LANES-1:0] neg_s3;

	logic [65:0] dpos [LANES];
	logic [64:0] dneg [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= sides_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			dpos[k] = {1'b0, sum_s2[k]} - {2'b00, rr_s2[k]};
			dneg[k] = {1'b0, rr_s2[k]} - sum_s2[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dg_s1    <= (sides.side_a == '0) || (sides.side_b == '0) || (sides.side_c == '0);
			sq_s1[0] <= 64'(sides.side_a) * 64'(sides.side_a);
			sq_s1[1] <= 64'(sides.side_b) * 64'(sides.side_b);
			sq_s1[2] <= 64'(sides.side_c) * 64'(sides.side_c);
			pq_s1[0] <= 64'(sides.side_b) * 64'(sides.side_c);
			pq_s1[1] <= 64'(sides.side_a) * 64'(sides.side_c);
			pq_s1[2] <= 64'(sides.side_a) * 64'(sides.side_b);
			dg_s2    <= dg_s1;
			dg_s3    <= dg_s2;
			for (int k = 0; k < LANES; k++) begin
				sum_s2[k] <= {1'b0, sq_s1[lane_p(k)]} + {1'b0, sq_s1[lane_q(k)]};
				rr_s2[k]  <= sq_s1[k];
				den_s2[k] <= {pq_s1[k], 1'b0};
				neg_s3[k] <= dpos[k][65];
				mag_s3[k] <= dpos[k][65] ? dneg[k] : dpos[k][64:0];
				den_s3[k] <= den_s2[k];
			end
		end
	end

	assign ctl = '{valid: v_s3, degen: dg_s3, neg: neg_s3};
	assign mag = mag_s3;
	assign den = den_s3;

endmodule

FILE: rtl/core/tang_div.sv
module tang_div import tang_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  ctl_t        ctl_in,
	input  logic [64:0] mag [LANES],
	input  logic [64:0] den [LANES],
	output ctl_t        ctl_out,
	output logic [30:0] cabs [LANES]
);

	ctl_t        ctl_s [DIV_STEPS+1];
	logic        sat_s [DIV_STEPS+1][LANES];
	logic [64:0] rem_s [DIV_STEPS+1][LANES];
	logic [64:0] den_s [DIV_STEPS+1][LANES];
	logic [29:0] q_s   [DIV_STEPS+1][LANES];

	logic [64:0] rem_n [DIV_STEPS][LANES];
	logic [29:0] q_n   [DIV_STEPS][LANES];

	always_comb begin
		for (int j = 0; j < DIV_STEPS; j++) begin
			for (int k = 0; k < LANES; k++) begin
				logic [65:0] r2;
				logic        ge;
				r2 = {rem_s[j][k], 1'b0};
				ge = r2 >= {1'b0, den_s[j][k]};
				rem_n[j][k] = ge ? 65'(r2 - {1'b0, den_s[j][k]}) : r2[64:0];
				q_n[j][k]   = {q_s[j][k][28:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= DIV_STEPS; j++)
				ctl_s[j] <= '0;
		end else if (en) begin
			ctl_s[0] <= ctl_in;
			for (int j = 0; j < DIV_STEPS; j++)
				ctl_s[j+1] <= ctl_s[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < LANES; k++) begin
				sat_s[0][k] <= mag[k] >= den[k];
				rem_s[0][k] <= mag[k];
				den_s[0][k] <= den[k];
				q_s[0][k]   <= '0;
				for (int j = 0; j < DIV_STEPS; j++) begin
					sat_s[j+1][k] <= sat_s[j][k];
					rem_s[j+1][k] <= rem_n[j][k];
					den_s[j+1][k] <= den_s[j][k];
					q_s[j+1][k]   <= q_n[j][k];
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < LANES; k++)
			cabs[k] = sat_s[DIV_STEPS][k] ? ONE_Q30 : {1'b0, q_s[DIV_STEPS][k]};
	end

	assign ctl_out = ctl_s[DIV_STEPS];

endmodule

FILE: rtl/core/tang_sqrt.sv
module tang_sqrt import tang_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  ctl_t        ctl_in,
	input  logic [30:0] cabs_in [LANES],
	output ctl_t        ctl_out,
	output logic [30:0] cabs_out [LANES],
	output logic [30:0] sn [LANES]
);

	ctl_t        ctl_a_s1;
	logic [30:0] cab_a_s1 [LANES];
	logic [61:0] sq_a_s1 [LANES];

	ctl_t        ctl_s [SQRT_STEPS+1];
	logic [30:0] cab_s [SQRT_STEPS+1][LANES];
	logic [60:0] v_s   [SQRT_STEPS+1][LANES];
	logic [60:0] res_s [SQRT_STEPS+1][LANES];

	logic [60:0] v_n   [SQRT_STEPS][LANES];
	logic [60:0] res_n [SQRT_STEPS][LANES];

	always_comb begin
		for (int j = 0; j < SQRT_STEPS; j++) begin
			for (int k = 0; k < LANES; k++) begin
				logic [60:0] bitv;
				logic [61:0] tst;
				logic        ge;
				bitv = 61'(1) << (60 - 2 * j);
				tst  = {1'b0, res_s[j][k]} + {1'b0, bitv};
				ge   = {1'b0, v_s[j][k]} >= tst;
				v_n[j][k]   = ge ? 61'({1'b0, v_s[j][k]} - tst) : v_s[j][k];
				res_n[j][k] = ge ? (res_s[j][k] >> 1) + bitv : res_s[j][k] >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_a_s1 <= '0;
			for (int j = 0; j <= SQRT_STEPS; j++)
				ctl_s[j] <= '0;
		end else if (en) begin
			ctl_a_s1 <= ctl_in;
			ctl_s[0] <= ctl_a_s1;
			for (int j = 0; j < SQRT_STEPS; j++)
				ctl_s[j+1] <= ctl_s[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < LANES; k++) begin
				cab_a_s1[k] <= cabs_in[k];
				sq_a_s1[k]  <= 62'(cabs_in[k]) * 62'(cabs_in[k]);
				cab_s[0][k] <= cab_a_s1[k];
				v_s[0][k]   <= 61'({1'b0, ONE_Q60} - {1'b0, sq_a_s1[k][60:0]});
				res_s[0][k] <= '0;
				for (int j = 0; j < SQRT_STEPS; j++) begin
					cab_s[j+1][k] <= cab_s[j][k];
					v_s[j+1][k]   <= v_n[j][k];
					res_s[j+1][k] <= res_n[j][k];
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			cabs_out[k] = cab_s[SQRT_STEPS][k];
			sn[k]       = res_s[SQRT_STEPS][k][30:0];
		end
	end

	assign ctl_out = ctl_s[SQRT_STEPS];

endmodule

FILE: rtl/core/tang_cordic.sv
module tang_cordic import tang_pkg::*; #(
	parameter int ITER = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  ctl_t                 ctl_in,
	input  logic [30:0]          cabs [LANES],
	input  logic [30:0]          sn [LANES],
	output ctl_t                 ctl_out,
	output logic signed [ZW-1:0] z [LANES]
);

	ctl_t                 ctl_s [ITER+1];
	logic signed [63:0]   x_s [ITER+1][LANES];
	logic signed [63:0]   y_s [ITER+1][LANES];
	logic signed [ZW-1:0] z_s [ITER+1][LANES];

	logic signed [63:0]   x_n [ITER][LANES];
	logic signed [63:0]   y_n [ITER][LANES];
	logic signed [ZW-1:0] z_n [ITER][LANES];

	always_comb begin
		for (int j = 0; j < ITER; j++) begin
			for (int k = 0; k < LANES; k++) begin
				logic signed [63:0]   dx;
				logic signed [63:0]   dy;
				logic signed [ZW-1:0] t;
				dx = y_s[j][k] >>> ((j > 63) ? 63 : j);
				dy = x_s[j][k] >>> ((j > 63) ? 63 : j);
				t  = ZW'(atan_q30(j));
				if (y_s[j][k] == '0) begin
					x_n[j][k] = x_s[j][k];
					y_n[j][k] = y_s[j][k];
					z_n[j][k] = z_s[j][k];
				end else if (y_s[j][k][63]) begin
					x_n[j][k] = x_s[j][k] - dx;
					y_n[j][k] = y_s[j][k] + dy;
					z_n[j][k] = z_s[j][k] - t;
				end else begin
					x_n[j][k] = x_s[j][k] + dx;
					y_n[j][k] = y_s[j][k] - dy;
					z_n[j][k] = z_s[j][k] + t;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= ITER; j++)
				ctl_s[j] <= '0;
		end else if (en) begin
			ctl_s[0] <= ctl_in;
			for (int j = 0; j < ITER; j++)
				ctl_s[j+1] <= ctl_s[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < LANES; k++) begin
				x_s[0][k] <= 64'(cabs[k]) << CORDIC_SCALE;
				y_s[0][k] <= 64'(sn[k]) << CORDIC_SCALE;
				z_s[0][k] <= '0;
				for (int j = 0; j < ITER; j++) begin
					x_s[j+1][k] <= x_n[j][k];
					y_s[j+1][k] <= y_n[j][k];
					z_s[j+1][k] <= z_n[j][k];
				end
			end
		end
	end

	assign z       = z_s[ITER];
	assign ctl_out = ctl_s[ITER];

endmodule

FILE: rtl/core/triangle_angles_from_sides.sv
// Throughput: one triangle per cycle while the output register is not stalled; every stage is a single register step of
// the product, divide, square-root or CORDIC pipelines.
// The whole pipeline holds while a result waits in the output register.
// Reset clears the valid bits and control words only; no clearing pass.
module triangle_angles_from_sides import tang_pkg::*; #(
	parameter int ACOS_ITERATIONS = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sides_valid,
	output logic    sides_ready,
	input  sides_t  sides,
	output logic    angles_valid,
	input  logic    angles_ready,
	output angles_t angles
);

	logic en;

	ctl_t                 ctl_f, ctl_d, ctl_r, ctl_c;
	logic [64:0]          mag [LANES];
	logic [64:0]          den [LANES];
	logic [30:0]          cabs_d [LANES];
	logic [30:0]          cabs_r [LANES];
	logic [30:0]          sn [LANES];
	logic signed [ZW-1:0] z [LANES];
	logic [31:0]          ang [LANES];

	logic    out_valid_q;
	angles_t out_q;

	assign en          = !out_valid_q || angles_ready;
	assign sides_ready = en;

	tang_front u_front (
		.clk, .arst_n, .en, .sides_valid, .sides,
		.ctl(ctl_f), .mag, .den
	);

	tang_div u_div (
		.clk, .arst_n, .en, .ctl_in(ctl_f), .mag, .den,
		.ctl_out(ctl_d), .cabs(cabs_d)
	);

	tang_sqrt u_sqrt (
		.clk, .arst_n, .en, .ctl_in(ctl_d), .cabs_in(cabs_d),
		.ctl_out(ctl_r), .cabs_out(cabs_r), .sn
	);

	tang_cordic #(.ITER(ACOS_ITERATIONS)) u_cordic (
		.clk, .arst_n, .en, .ctl_in(ctl_r), .cabs(cabs_r), .sn,
		.ctl_out(ctl_c), .z
	);

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			logic [30:0] zc;
			if (z[k][ZW-1])
				zc = '0;
			else if (z[k] > $signed({{(ZW-31){1'b0}}, HALF_PI_Q30}))
				zc = HALF_PI_Q30;
			else
				zc = z[k][30:0];
			if (ctl_c.degen)
				ang[k] = '0;
			else if (ctl_c.neg[k])
				ang[k] = PI_Q30 - {1'b0, zc};
			else
				ang[k] = {1'b0, zc};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_c.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.angle_alpha <= ang[0];
			out_q.angle_beta  <= ang[1];
			out_q.angle_gamma <= ang[2];
			out_q.degenerate  <= ctl_c.degen;
		end
	end

	assign angles_valid = out_valid_q;
	assign angles       = out_q;

endmodule
